FILE: hdl/jes_pkg.sv
// shared types and constants of the joint enable sequencer
// no dependencies; used by jes_ctrl, jes_dp and joint_enable_sequencer_unit
package jes_pkg;

	localparam int unsigned NUM_JOINTS = 3;

	// input word kinds
	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_ENABLE  = 2'd1;
	localparam logic [1:0] KIND_DISABLE = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	// result kinds
	localparam logic [1:0] RES_POSITION = 2'd0;
	localparam logic [1:0] RES_INTERNAL = 2'd1;
	localparam logic [1:0] RES_JOINT    = 2'd2;

	// joint commands
	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_RESET   = 2'd1;
	localparam logic [1:0] CMD_ENABLE  = 2'd2;
	localparam logic [1:0] CMD_DISABLE = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_JOINT_COUNT = 3'd0;
	localparam logic [2:0] CFG_BASE_FIRST  = 3'd1;
	localparam logic [2:0] CFG_BASE_SECOND = 3'd2;
	localparam logic [2:0] CFG_BASE_THIRD  = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT     = 3'd4;

	// configuration reset values
	localparam logic [1:0]  RST_JOINT_COUNT = 2'd3;
	localparam logic [10:0] RST_BASE_FIRST  = 11'd16;
	localparam logic [10:0] RST_BASE_SECOND = 11'd32;
	localparam logic [10:0] RST_BASE_THIRD  = 11'd48;
	localparam logic [15:0] RST_TIMEOUT     = 16'd40;

	// error byte codes
	localparam logic [7:0] ERR_READY     = 8'h04;
	localparam logic [7:0] ERR_NONE      = 8'h00;
	localparam logic [7:0] MARK_INTERNAL = 8'hE0;

	typedef enum logic [2:0] {
		M_INIT      = 3'd0,
		M_ERRRESET  = 3'd1,
		M_ENABLING  = 3'd2,
		M_ENABLED   = 3'd3,
		M_DISABLING = 3'd4,
		M_DISABLED  = 3'd5
	} joint_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRAME,
		ST_TICK,
		ST_ARM,
		ST_EMIT
	} jes_state_t;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       do_frame;
		logic       do_tick;
		logic       do_arm;
		logic       do_emit;
		logic [1:0] idx;
	} jes_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] n_used;
		logic [1:0] res_cnt;
		logic       out_free;
	} jes_stat_t;

endpackage

FILE: hdl/jes_ctrl.sv
// controller state machine of the joint enable sequencer
// depends on jes_pkg; drives jes_dp through jes_cmd_t
module jes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_kind,
	output logic              in_stall,
	output jes_pkg::jes_cmd_t cmd_o,
	input  jes_pkg::jes_stat_t stat_i
);

	jes_pkg::jes_state_t state_q, state_n;
	logic [1:0] idx_q, idx_n;
	logic       take;

	assign in_stall = (state_q != jes_pkg::ST_IDLE);
	assign take     = in_valid && !in_stall;

	always_comb begin
		state_n = state_q;
		idx_n   = idx_q;
		case (state_q)
			jes_pkg::ST_IDLE: begin
				idx_n = 2'd0;
				if (take && in_kind == jes_pkg::KIND_FRAME) begin
					state_n = jes_pkg::ST_FRAME;
				end else if (take && in_kind == jes_pkg::KIND_TICK) begin
					state_n = jes_pkg::ST_TICK;
				end
			end
			jes_pkg::ST_FRAME: begin
				state_n = jes_pkg::ST_EMIT;
				idx_n   = 2'd0;
			end
			jes_pkg::ST_TICK: begin
				if (idx_q == stat_i.n_used - 2'd1) begin
					state_n = jes_pkg::ST_ARM;
					idx_n   = 2'd0;
				end else begin
					idx_n = idx_q + 2'd1;
				end
			end
			jes_pkg::ST_ARM: begin
				state_n = jes_pkg::ST_EMIT;
				idx_n   = 2'd0;
			end
			jes_pkg::ST_EMIT: begin
				if (stat_i.res_cnt == 2'd0) begin
					state_n = jes_pkg::ST_IDLE;
				end else if (stat_i.out_free) begin
					if (idx_q == stat_i.res_cnt - 2'd1) begin
						state_n = jes_pkg::ST_IDLE;
					end else begin
						idx_n = idx_q + 2'd1;
					end
				end
			end
			default: begin
				state_n = jes_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_o          = '0;
		cmd_o.take     = take;
		cmd_o.idx      = idx_q;
		case (state_q)
			jes_pkg::ST_FRAME: cmd_o.do_frame = 1'b1;
			jes_pkg::ST_TICK:  cmd_o.do_tick  = 1'b1;
			jes_pkg::ST_ARM:   cmd_o.do_arm   = 1'b1;
			jes_pkg::ST_EMIT:  cmd_o.do_emit  = (stat_i.res_cnt != 2'd0) && stat_i.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jes_pkg::ST_IDLE;
			idx_q   <= 2'd0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
		end
	end

	// the emit counter never runs past the buffered results
	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.do_emit |-> (idx_q < stat_i.res_cnt))
		else $error("emit index beyond result count");

endmodule

FILE: hdl/jes_dp.sv
// datapath of the joint enable sequencer: config, joint state, joint update,
// result buffer and output register; depends on jes_pkg, commanded by jes_ctrl
module jes_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  jes_pkg::jes_cmd_t  cmd_i,
	output jes_pkg::jes_stat_t stat_o,
	input  logic [1:0]         kind,
	input  logic [10:0]        can_id,
	input  logic [7:0]         first_byte,
	input  logic [31:0]        payload_word,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         result_kind,
	output logic [1:0]         joint_index,
	output logic signed [31:0] position_ticks,
	output logic [7:0]         error_byte,
	output logic [1:0]         command,
	output logic [2:0]         joint_mode,
	output logic               timed_out,
	output logic               arm_enabled,
	output logic               last
);

	localparam int unsigned NJ = jes_pkg::NUM_JOINTS;

	// configuration
	logic [1:0]  jc_q;
	logic [10:0] base_q [NJ];
	logic [15:0] tmo_q;

	// joint state
	jes_pkg::joint_mode_t mode_q [NJ];
	logic [7:0]  err_q [NJ];
	logic [15:0] timer_q [NJ];
	logic [NJ-1:0] en_pend_q, dis_pend_q;
	logic        arm_q, chk_q;
	logic [1:0]  sel_q;

	// latched input word
	logic [10:0] id_q;
	logic [7:0]  byte_q;
	logic [31:0] word_q;

	// result buffer
	logic [1:0]  rb_kind_q [NJ];
	logic [1:0]  rb_joint_q [NJ];
	logic [31:0] rb_pos_q [NJ];
	logic [7:0]  rb_err_q [NJ];
	logic [1:0]  rb_cmd_q [NJ];
	logic [2:0]  rb_mode_q [NJ];
	logic        rb_tmo_q [NJ];
	logic [1:0]  cnt_q;

	logic [1:0]  n_used;
	logic        out_free;

	assign n_used   = (jc_q == 2'd0) ? 2'd1 : jc_q;
	assign out_free = !out_valid || !out_stall;

	assign stat_o.n_used   = n_used;
	assign stat_o.res_cnt  = cnt_q;
	assign stat_o.out_free = out_free;

	// frame decode
	logic [11:0] id12;
	logic [1:0]  sel_n;
	logic        sel_used, hit_pos, hit_int;

	always_comb begin
		id12 = {1'b0, id_q};
		if (id12 < {1'b0, base_q[0]} + 12'd4) begin
			sel_n = 2'd0;
		end else if (id12 < {1'b0, base_q[1]} + 12'd4) begin
			sel_n = 2'd1;
		end else if (id_q >= base_q[2]) begin
			sel_n = 2'd2;
		end else begin
			sel_n = sel_q;
		end
		sel_used = sel_n < n_used;
		hit_pos  = sel_used && (id12 == {1'b0, base_q[sel_n]} + 12'd1);
		hit_int  = sel_used && (id12 == {1'b0, base_q[sel_n]} + 12'd2)
			&& (byte_q == jes_pkg::MARK_INTERNAL) && (word_q != 32'd0);
	end

	// one joint update per cycle, joint chosen by the controller's counter
	logic [1:0]  j;
	logic [7:0]  e;
	logic [16:0] elapsed;
	logic        expired;
	logic [15:0] wait_cnt, tmr_n;
	jes_pkg::joint_mode_t m_n;
	logic [1:0]  jcmd;
	logic        jtmo, en_clr, dis_clr, chk_set;

	always_comb begin
		j        = cmd_i.idx;
		e        = err_q[j];
		elapsed  = {1'b0, timer_q[j]} + 17'd1;
		expired  = elapsed > {1'b0, tmo_q};
		wait_cnt = elapsed[16] ? 16'hFFFF : elapsed[15:0];
		m_n      = mode_q[j];
		tmr_n    = timer_q[j];
		jcmd     = jes_pkg::CMD_NONE;
		jtmo     = 1'b0;
		en_clr   = 1'b0;
		dis_clr  = 1'b0;
		chk_set  = 1'b0;
		case (mode_q[j])
			jes_pkg::M_INIT: begin
				if (en_pend_q[j]) begin
					m_n = jes_pkg::M_ERRRESET; jcmd = jes_pkg::CMD_RESET; tmr_n = 16'd0;
				end
			end
			jes_pkg::M_ERRRESET: begin
				if (e == jes_pkg::ERR_READY) begin
					m_n = jes_pkg::M_ENABLING; chk_set = 1'b1;
					jcmd = jes_pkg::CMD_ENABLE; tmr_n = 16'd0;
				end else if (expired) begin
					m_n = jes_pkg::M_INIT; jtmo = 1'b1;
				end else begin
					tmr_n = wait_cnt;
				end
			end
			jes_pkg::M_ENABLING: begin
				if (e == jes_pkg::ERR_NONE) begin
					m_n = jes_pkg::M_ENABLED; en_clr = 1'b1;
				end else if (expired) begin
					m_n = jes_pkg::M_DISABLED; jtmo = 1'b1;
				end else begin
					tmr_n = wait_cnt;
				end
			end
			jes_pkg::M_ENABLED: begin
				if (e != jes_pkg::ERR_NONE) begin
					m_n = jes_pkg::M_INIT;
				end else if (dis_pend_q[j]) begin
					m_n = jes_pkg::M_DISABLING; chk_set = 1'b1;
					jcmd = jes_pkg::CMD_DISABLE; tmr_n = 16'd0;
				end
			end
			jes_pkg::M_DISABLING: begin
				if (e == jes_pkg::ERR_READY) begin
					m_n = jes_pkg::M_DISABLED; dis_clr = 1'b1;
				end else if (expired) begin
					m_n = jes_pkg::M_ENABLED; jtmo = 1'b1;
				end else begin
					tmr_n = wait_cnt;
				end
			end
			jes_pkg::M_DISABLED: begin
				if (e != jes_pkg::ERR_READY) begin
					m_n = jes_pkg::M_INIT;
				end else if (en_pend_q[j]) begin
					m_n = jes_pkg::M_ENABLING; chk_set = 1'b1;
					jcmd = jes_pkg::CMD_ENABLE; tmr_n = 16'd0;
				end
			end
			default: ;
		endcase
	end

	// arm check over joints in use
	logic all_on, all_off;

	always_comb begin
		all_on  = 1'b1;
		all_off = 1'b1;
		for (int k = 0; k < NJ; k++) begin
			if (k < int'(n_used)) begin
				all_on  = all_on && (mode_q[k] == jes_pkg::M_ENABLED);
				all_off = all_off && (mode_q[k] == jes_pkg::M_DISABLED);
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jc_q       <= jes_pkg::RST_JOINT_COUNT;
			base_q[0]  <= jes_pkg::RST_BASE_FIRST;
			base_q[1]  <= jes_pkg::RST_BASE_SECOND;
			base_q[2]  <= jes_pkg::RST_BASE_THIRD;
			tmo_q      <= jes_pkg::RST_TIMEOUT;
			for (int k = 0; k < NJ; k++) begin
				mode_q[k]  <= jes_pkg::M_INIT;
				err_q[k]   <= 8'd0;
				timer_q[k] <= 16'd0;
			end
			en_pend_q  <= '0;
			dis_pend_q <= '0;
			arm_q      <= 1'b0;
			chk_q      <= 1'b0;
			sel_q      <= 2'd0;
			cnt_q      <= 2'd0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					jes_pkg::CFG_JOINT_COUNT: jc_q      <= cfg_data[1:0];
					jes_pkg::CFG_BASE_FIRST:  base_q[0] <= cfg_data[10:0];
					jes_pkg::CFG_BASE_SECOND: base_q[1] <= cfg_data[10:0];
					jes_pkg::CFG_BASE_THIRD:  base_q[2] <= cfg_data[10:0];
					jes_pkg::CFG_TIMEOUT:     tmo_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd_i.take && kind == jes_pkg::KIND_ENABLE) begin
				en_pend_q <= '1;
			end
			if (cmd_i.take && kind == jes_pkg::KIND_DISABLE) begin
				dis_pend_q <= '1;
			end
			if (cmd_i.do_frame) begin
				sel_q <= sel_n;
				cnt_q <= (hit_pos || hit_int) ? 2'd1 : 2'd0;
				if (hit_pos) begin
					err_q[sel_n] <= byte_q;
				end
			end
			if (cmd_i.do_tick) begin
				mode_q[j]  <= m_n;
				timer_q[j] <= tmr_n;
				if (en_clr) begin
					en_pend_q[j] <= 1'b0;
				end
				if (dis_clr) begin
					dis_pend_q[j] <= 1'b0;
				end
				if (chk_set) begin
					chk_q <= 1'b1;
				end
			end
			if (cmd_i.do_arm) begin
				cnt_q <= n_used;
				if (chk_q && all_on) begin
					arm_q <= 1'b1; chk_q <= 1'b0;
				end else if (chk_q && all_off) begin
					arm_q <= 1'b0; chk_q <= 1'b0;
				end
			end
			if (cmd_i.do_emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_i.take) begin
			id_q   <= can_id;
			byte_q <= first_byte;
			word_q <= payload_word;
		end
		if (cmd_i.do_frame) begin
			rb_kind_q[0]  <= hit_pos ? jes_pkg::RES_POSITION : jes_pkg::RES_INTERNAL;
			rb_joint_q[0] <= sel_n;
			rb_pos_q[0]   <= hit_pos ? word_q : 32'd0;
			rb_err_q[0]   <= hit_pos ? byte_q : err_q[sel_n];
			rb_cmd_q[0]   <= jes_pkg::CMD_NONE;
			rb_mode_q[0]  <= mode_q[sel_n];
			rb_tmo_q[0]   <= 1'b0;
		end
		if (cmd_i.do_tick) begin
			rb_kind_q[j]  <= jes_pkg::RES_JOINT;
			rb_joint_q[j] <= j;
			rb_pos_q[j]   <= 32'd0;
			rb_err_q[j]   <= e;
			rb_cmd_q[j]   <= jcmd;
			rb_mode_q[j]  <= m_n;
			rb_tmo_q[j]   <= jtmo;
		end
		if (cmd_i.do_emit) begin
			result_kind    <= rb_kind_q[cmd_i.idx];
			joint_index    <= rb_joint_q[cmd_i.idx];
			position_ticks <= $signed(rb_pos_q[cmd_i.idx]);
			error_byte     <= rb_err_q[cmd_i.idx];
			command        <= rb_cmd_q[cmd_i.idx];
			joint_mode     <= rb_mode_q[cmd_i.idx];
			timed_out      <= rb_tmo_q[cmd_i.idx];
			arm_enabled    <= arm_q;
			last           <= (cmd_i.idx == cnt_q - 2'd1);
		end
	end

	// joint walk stays inside the joints in use
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.do_tick |-> (cmd_i.idx < n_used))
		else $error("tick update on unused joint");

	// a result is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.do_emit |-> out_free)
		else $error("output register overwritten");

	// a frame, tick or arm step never overlaps an emit
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_i.do_frame || cmd_i.do_arm || cmd_i.do_tick) |-> !cmd_i.do_emit)
		else $error("datapath steps overlap");

endmodule

FILE: hdl/joint_enable_sequencer_unit.sv
// a request word only sets the pending flags; a frame word goes through frame decode
// and then the emit step; a tick word takes one shared joint update step per joint
// in use, one arm check, then one result loaded per cycle while the output is free
// input stalls until the last result is loaded into the single output register
// reset: asynchronous, active low; config back to defaults, all joints in init
// top level of the joint enable sequencer; depends on jes_pkg, jes_ctrl and jes_dp
module joint_enable_sequencer_unit (
	input  logic               clk,
	input  logic               arst_n,

	// input word channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [10:0]        can_id,
	input  logic [7:0]         first_byte,
	input  logic [31:0]        payload_word,

	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,

	// result word channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic [1:0]         joint_index,
	output logic signed [31:0] position_ticks,
	output logic [7:0]         error_byte,
	output logic [1:0]         command,
	output logic [2:0]         joint_mode,
	output logic               timed_out,
	output logic               arm_enabled,
	output logic               last
);

	jes_pkg::jes_cmd_t  cmd;
	jes_pkg::jes_stat_t stat;

	// config writes land directly in the datapath registers
	assign cfg_ready = 1'b1;

	// controller: accepts a word only when idle, walks joints, paces results
	jes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (kind),
		.in_stall (in_stall),
		.cmd_o    (cmd),
		.stat_i   (stat)
	);

	// datapath: joint state, frame decode, joint update, result buffer
	jes_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_i          (cmd),
		.stat_o         (stat),
		.kind           (kind),
		.can_id         (can_id),
		.first_byte     (first_byte),
		.payload_word   (payload_word),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.result_kind    (result_kind),
		.joint_index    (joint_index),
		.position_ticks (position_ticks),
		.error_byte     (error_byte),
		.command        (command),
		.joint_mode     (joint_mode),
		.timed_out      (timed_out),
		.arm_enabled    (arm_enabled),
		.last           (last)
	);

	// an accepted tick or frame word keeps the input stalled next cycle
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (kind == jes_pkg::KIND_TICK || kind == jes_pkg::KIND_FRAME))
		|=> in_stall)
		else $error("input accepted while a word is in work");

endmodule

FILE: tb/tb.sv
// self-checking testbench of joint_enable_sequencer_unit: directed and random words against a
// built-in predictor of the joint sequencing, with random idling, stalls and one long hold-off
// depends on jes_pkg and joint_enable_sequencer_unit
module tb;
	import jes_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 300000;
	localparam int unsigned HOLD_CYCLES  = 120;
	// wait after the last expected result before a register write
	localparam int unsigned SETTLE_CYCLES = 16;
	// register index with no register behind it
	localparam logic [2:0] CFG_UNUSED = 3'd7;

	// one result word as seen on the output ports
	typedef struct packed {
		logic [1:0]  rkind;
		logic [1:0]  jidx;
		logic [31:0] ticks;
		logic [7:0]  ebyte;
		logic [1:0]  cmd;
		logic [2:0]  jmode;
		logic        tmo;
		logic        armed;
		logic        fin;
	} result_t;

	// predictor of the joint sequencer and store of the results it still owes
	class joint_tracker;
		logic [1:0]  n_cfg;
		logic [10:0] base [3];
		logic [15:0] tmo_lim;

		joint_mode_t mode [3];
		logic [7:0]  err [3];
		logic [15:0] wt [3];
		bit          en_req [3];
		bit          dis_req [3];
		bit          arm;
		bit          arm_check;
		int unsigned sel;

		result_t     fresh [$];
		result_t     due_results [$];
		int unsigned fails;

		function new();
			n_cfg = RST_JOINT_COUNT;
			base[0] = RST_BASE_FIRST;
			base[1] = RST_BASE_SECOND;
			base[2] = RST_BASE_THIRD;
			tmo_lim = RST_TIMEOUT;
			for (int j = 0; j < 3; j++) begin
				mode[j] = M_INIT;
				err[j] = 8'h00;
				wt[j] = 16'h0000;
				en_req[j] = 1'b0;
				dis_req[j] = 1'b0;
			end
			arm = 1'b0;
			arm_check = 1'b0;
			sel = 0;
			fails = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] v);
			case (idx)
				CFG_JOINT_COUNT: n_cfg = v[1:0];
				CFG_BASE_FIRST:  base[0] = v[10:0];
				CFG_BASE_SECOND: base[1] = v[10:0];
				CFG_BASE_THIRD:  base[2] = v[10:0];
				CFG_TIMEOUT:     tmo_lim = v;
				default: ;
			endcase
		endfunction

		function int unsigned joints_in_use();
			return (n_cfg == 2'd0) ? 1 : int'(n_cfg);
		endfunction

		// counts one waiting tick, 1 once the wait is over the limit
		function bit timer_expired(int j);
			int unsigned el;
			el = int'(wt[j]) + 1;
			if (el > int'(tmo_lim))
				return 1'b1;
			wt[j] = (el > 32'hFFFF) ? 16'hFFFF : el[15:0];
			return 1'b0;
		endfunction

		function void add_result(logic [1:0] rk, int j, logic [31:0] p, logic [1:0] c, logic t);
			result_t r;
			r.rkind = rk;
			r.jidx = j[1:0];
			r.ticks = p;
			r.ebyte = err[j];
			r.cmd = c;
			r.jmode = mode[j];
			r.tmo = t;
			r.armed = 1'b0;
			r.fin = 1'b0;
			fresh.insert(fresh.size(), r);
		endfunction

		function void step_frame(logic [10:0] id, logic [7:0] b0, logic [31:0] w);
			int unsigned idv;
			int unsigned bj;
			idv = 32'(id);
			// sums are compared without wrapping at 11 bits
			if (idv < int'(base[0]) + 4)
				sel = 0;
			else if (idv < int'(base[1]) + 4)
				sel = 1;
			else if (idv >= int'(base[2]))
				sel = 2;
			if (sel >= joints_in_use())
				return;
			bj = 32'(base[sel]);
			if (idv == bj + 1) begin
				err[sel] = b0;
				add_result(RES_POSITION, sel, w, CMD_NONE, 1'b0);
			end else if (idv == bj + 2 && b0 == MARK_INTERNAL && w != 32'd0) begin
				add_result(RES_INTERNAL, sel, 32'd0, CMD_NONE, 1'b0);
			end
		endfunction

		function void step_tick();
			int unsigned n;
			bit all_on;
			bit all_off;
			n = joints_in_use();
			for (int j = 0; j < n; j++) begin
				logic [1:0] c;
				logic       t;
				logic [7:0] e;
				c = CMD_NONE;
				t = 1'b0;
				e = err[j];
				case (mode[j])
					M_INIT: begin
						if (en_req[j]) begin
							mode[j] = M_ERRRESET;
							c = CMD_RESET;
							wt[j] = 16'h0000;
						end
					end
					M_ERRRESET: begin
						if (e == ERR_READY) begin
							mode[j] = M_ENABLING;
							arm_check = 1'b1;
							c = CMD_ENABLE;
							wt[j] = 16'h0000;
						end else if (timer_expired(j)) begin
							mode[j] = M_INIT;
							t = 1'b1;
						end
					end
					M_ENABLING: begin
						if (e == ERR_NONE) begin
							mode[j] = M_ENABLED;
							en_req[j] = 1'b0;
						end else if (timer_expired(j)) begin
							mode[j] = M_DISABLED;
							t = 1'b1;
						end
					end
					M_ENABLED: begin
						if (e != ERR_NONE) begin
							mode[j] = M_INIT;
						end else if (dis_req[j]) begin
							mode[j] = M_DISABLING;
							arm_check = 1'b1;
							c = CMD_DISABLE;
							wt[j] = 16'h0000;
						end
					end
					M_DISABLING: begin
						if (e == ERR_READY) begin
							dis_req[j] = 1'b0;
							mode[j] = M_DISABLED;
						end else if (timer_expired(j)) begin
							mode[j] = M_ENABLED;
							t = 1'b1;
						end
					end
					M_DISABLED: begin
						if (e != ERR_READY) begin
							mode[j] = M_INIT;
						end else if (en_req[j]) begin
							mode[j] = M_ENABLING;
							arm_check = 1'b1;
							c = CMD_ENABLE;
							wt[j] = 16'h0000;
						end
					end
					default: ;
				endcase
				add_result(RES_JOINT, j, 32'd0, c, t);
			end
			if (arm_check) begin
				all_on = 1'b1;
				all_off = 1'b1;
				for (int j = 0; j < n; j++) begin
					all_on = all_on && (mode[j] == M_ENABLED);
					all_off = all_off && (mode[j] == M_DISABLED);
				end
				if (all_on) begin
					arm = 1'b1;
					arm_check = 1'b0;
				end else if (all_off) begin
					arm = 1'b0;
					arm_check = 1'b0;
				end
			end
		endfunction

		// called for every accepted input word
		function void note_word(logic [1:0] k, logic [10:0] id, logic [7:0] b0, logic [31:0] w);
			fresh.delete();
			case (k)
				KIND_FRAME: step_frame(id, b0, w);
				KIND_ENABLE: for (int j = 0; j < 3; j++) en_req[j] = 1'b1;
				KIND_DISABLE: for (int j = 0; j < 3; j++) dis_req[j] = 1'b1;
				default: step_tick();
			endcase
			for (int i = 0; i < fresh.size(); i++) begin
				fresh[i].armed = arm;
				fresh[i].fin = (i == fresh.size() - 1);
				due_results.insert(due_results.size(), fresh[i]);
			end
		endfunction

		function string show(result_t r);
			return $sformatf(
				"kind=%0d joint=%0d ticks=%h err=%h cmd=%0d mode=%0d tmo=%b arm=%b last=%b",
				r.rkind, r.jidx, r.ticks, r.ebyte, r.cmd, r.jmode, r.tmo, r.armed, r.fin);
		endfunction

		// called for every accepted result word
		function void check_word(result_t got);
			result_t exp;
			bit bad;
			if (due_results.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result word: %s", show(got));
				return;
			end
			exp = due_results.pop_front();
			bad = (got.rkind !== exp.rkind) || (got.jidx !== exp.jidx) ||
				(got.ticks !== exp.ticks) || (got.ebyte !== exp.ebyte) ||
				(got.cmd !== exp.cmd) || (got.jmode !== exp.jmode) ||
				(got.tmo !== exp.tmo) || (got.armed !== exp.armed) || (got.fin !== exp.fin);
			if (bad) begin
				fails++;
				if (fails <= 10) begin
					$display("result mismatch at %0t", $realtime);
					$display("  expected %s", show(exp));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_FRAME;
	logic [10:0] can_id = 11'd0;
	logic [7:0]  first_byte = 8'd0;
	logic [31:0] payload_word = 32'd0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_JOINT_COUNT;
	logic [15:0] cfg_data = 16'd0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         result_kind;
	logic [1:0]         joint_index;
	logic signed [31:0] position_ticks;
	logic [7:0]         error_byte;
	logic [1:0]         command;
	logic [2:0]         joint_mode;
	logic               timed_out;
	logic               arm_enabled;
	logic               last;

	joint_tracker board = new();

	// no idling on either side while set
	bit calm = 1'b0;
	// asks the receiver for one long hold-off
	bit hold_req = 1'b0;
	int unsigned cyc = 0;

	joint_enable_sequencer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.can_id        (can_id),
		.first_byte    (first_byte),
		.payload_word  (payload_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.joint_index   (joint_index),
		.position_ticks(position_ticks),
		.error_byte    (error_byte),
		.command       (command),
		.joint_mode    (joint_mode),
		.timed_out     (timed_out),
		.arm_enabled   (arm_enabled),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one input word; stall is sampled at the falling edge, where nothing the
	// testbench drives can still move before the next rising edge
	task automatic send_word(logic [1:0] k, logic [10:0] id, logic [7:0] b0, logic [31:0] w);
		bit took;
		if (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		can_id <= id;
		first_byte <= b0;
		payload_word <= w;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		board.note_word(k, id, b0, w);
	endtask

	// register write; valid stays up for a following write, the caller lowers it
	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		bit took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		board.set_reg(idx, v);
	endtask

	task automatic apply_setting(logic [1:0] jc, logic [10:0] b0, logic [10:0] b1,
			logic [10:0] b2, logic [15:0] lim);
		write_reg(CFG_JOINT_COUNT, {14'd0, jc});
		write_reg(CFG_BASE_FIRST, {5'd0, b0});
		write_reg(CFG_BASE_SECOND, {5'd0, b1});
		write_reg(CFG_BASE_THIRD, {5'd0, b2});
		write_reg(CFG_TIMEOUT, lim);
		cfg_valid <= 1'b0;
	endtask

	// all owed results in, then room for words that give none
	task automatic wait_idle();
		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed traffic: ticks, requests and status frames aimed at a
	// joint's base+1 with ready/none error bytes, plus marker frames and noise
	task automatic send_random(int count);
		int unsigned r;
		int unsigned j;
		int unsigned off;
		logic [7:0]  b0;
		logic [31:0] w;
		logic [10:0] id;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			w = $urandom;
			id = 11'($urandom);
			b0 = 8'($urandom);
			if (r < 30) begin
				send_word(KIND_TICK, id, b0, w);
			end else if (r < 40) begin
				send_word(KIND_ENABLE, id, b0, w);
			end else if (r < 47) begin
				send_word(KIND_DISABLE, id, b0, w);
			end else if (r < 90) begin
				j = $urandom_range(2);
				r = $urandom_range(99);
				off = (r < 75) ? 1 : (r < 90) ? 2 : $urandom_range(3);
				if (off == 2) begin
					if ($urandom_range(99) < 70)
						b0 = MARK_INTERNAL;
					if ($urandom_range(99) < 30)
						w = 32'd0;
				end else begin
					r = $urandom_range(99);
					if (r < 45)
						b0 = ERR_READY;
					else if (r < 80)
						b0 = ERR_NONE;
				end
				id = 11'(int'(board.base[j]) + off);
				send_word(KIND_FRAME, id, b0, w);
			end else begin
				send_word(2'($urandom), id, b0, w);
			end
		end
		in_valid <= 1'b0;
	endtask

	// receiver stall: random idling, or one long hold-off while the sender
	// keeps offering words so the block backs up into its input
	initial begin
		int unsigned hold_left;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				hold_left = HOLD_CYCLES;
				while (hold_left != 0) begin
					@(posedge clk);
					hold_left--;
				end
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 6);
			end
		end
	end

	// result words are taken at the rising edge that follows this sample
	always @(negedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.rkind = result_kind;
			got.jidx = joint_index;
			got.ticks = position_ticks;
			got.ebyte = error_byte;
			got.cmd = command;
			got.jmode = joint_mode;
			got.tmo = timed_out;
			got.armed = arm_enabled;
			got.fin = last;
			board.check_word(got);
		end
	end

	// run limit
	initial begin
		while (cyc < LIMIT_CYCLES) begin
			@(posedge clk);
			cyc++;
		end
		$display("timeout after %0d cycles", cyc);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings: field extremes, every word kind,
		// ignored identifiers and one full enable/disable walk of all joints
		send_word(KIND_TICK, 11'd0, 8'h00, 32'd0);
		send_word(KIND_FRAME, 11'd17, ERR_READY, 32'h8000_0000);
		send_word(KIND_FRAME, 11'd33, 8'hFF, 32'h7FFF_FFFF);
		send_word(KIND_FRAME, 11'd49, ERR_READY, 32'hFFFF_FFFF);
		send_word(KIND_FRAME, 11'd18, MARK_INTERNAL, 32'd1);
		// marker with zero payload, wrong marker: no report
		send_word(KIND_FRAME, 11'd50, MARK_INTERNAL, 32'd0);
		send_word(KIND_FRAME, 11'd34, 8'hE1, 32'd5);
		// base and base+3 give nothing, top identifier steers to joint two
		send_word(KIND_FRAME, 11'd16, ERR_READY, 32'd7);
		send_word(KIND_FRAME, 11'd19, ERR_READY, 32'd7);
		send_word(KIND_FRAME, 11'd2047, 8'hFF, 32'hFFFF_FFFF);
		// gap between joint ranges keeps the previous joint
		send_word(KIND_FRAME, 11'd40, ERR_READY, 32'd9);
		send_word(KIND_ENABLE, 11'd0, 8'h00, 32'd0);
		send_word(KIND_TICK, 11'd0, 8'h00, 32'd0);
		send_word(KIND_TICK, 11'd0, 8'h00, 32'd0);
		send_word(KIND_FRAME, 11'd17, ERR_NONE, 32'd0);
		send_word(KIND_FRAME, 11'd49, ERR_NONE, 32'd0);
		send_word(KIND_FRAME, 11'd33, ERR_READY, 32'd0);
		send_word(KIND_TICK, 11'd0, 8'h00, 32'd0);
		send_word(KIND_FRAME, 11'd33, ERR_NONE, 32'd0);
		send_word(KIND_TICK, 11'd0, 8'h00, 32'd0);
		send_word(KIND_DISABLE, 11'd0, 8'h00, 32'd0);
		send_word(KIND_TICK, 11'd0, 8'h00, 32'd0);
		send_word(KIND_FRAME, 11'd17, ERR_READY, 32'd0);
		send_word(KIND_FRAME, 11'd33, ERR_READY, 32'd0);
		send_word(KIND_FRAME, 11'd49, ERR_READY, 32'd0);
		send_word(KIND_TICK, 11'd0, 8'h00, 32'd0);
		in_valid <= 1'b0;
		wait_idle();

		// short timeout, receiver holds off for a long stretch
		apply_setting(2'd3, 11'd16, 11'd32, 11'd48, 16'd2);
		hold_req = 1'b1;
		send_random(50);
		wait_idle();

		// one joint, zero timeout expires on the first waiting tick
		apply_setting(2'd1, 11'd100, 11'd200, 11'd300, 16'd0);
		send_random(40);
		wait_idle();

		// base extremes: joint one's base+1 lies past the identifier range
		write_reg(CFG_UNUSED, 16'hFFFF);
		apply_setting(2'd2, 11'd0, 11'd2047, 11'd2047, 16'd1);
		send_random(40);
		wait_idle();

		// zero joint count behaves as one, longest timeout
		apply_setting(2'd0, 11'd2040, 11'd5, 11'd2046, 16'hFFFF);
		send_random(30);
		wait_idle();

		// back to three joints with no idling on either side
		apply_setting(2'd3, 11'd16, 11'd32, 11'd48, 16'd3);
		calm = 1'b1;
		send_random(60);
		wait_idle();
		calm = 1'b0;

		if (board.fails == 0 && board.due_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("failures: %0d, results still owed: %0d", board.fails,
				board.due_results.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
